>>> rtl/core/wavhp_pkg.sv
// wavhp_pkg: shared types and constants for the wav pcm16 header parser
// used by wavhp_core, wav_pcm16_header_parser and the verif bench, no dependencies
package wavhp_pkg;

  // default width of the byte position counter
  localparam int POSITION_BITS_DEF = 32;

  // chunk and magic identifiers, little-endian as they arrive
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // stream limits
  localparam logic [31:0] MIN_STREAM   = 32'd44;
  localparam logic [31:0] FMT_MIN      = 32'd16;
  localparam logic [32:0] CHUNK_HDR    = 33'd8;
  localparam logic [31:0] MIN_DATA_OFF = 32'd20;

  // byte positions that close the riff, size and wave fields
  localparam logic [31:0] POS_RIFF_END  = 32'd3;
  localparam logic [31:0] POS_RSIZE_END = 32'd7;
  localparam logic [31:0] POS_WAVE_END  = 32'd11;

  // byte offsets inside a fmt body
  localparam logic [3:0] FMT_FORMAT_LO = 4'd0;
  localparam logic [3:0] FMT_FORMAT_HI = 4'd1;
  localparam logic [3:0] FMT_CHAN_LO   = 4'd2;
  localparam logic [3:0] FMT_CHAN_HI   = 4'd3;
  localparam logic [3:0] FMT_RATE_B0   = 4'd4;
  localparam logic [3:0] FMT_RATE_B1   = 4'd5;
  localparam logic [3:0] FMT_RATE_B2   = 4'd6;
  localparam logic [3:0] FMT_RATE_B3   = 4'd7;
  localparam logic [3:0] FMT_BITS_LO   = 4'd14;
  localparam logic [3:0] FMT_BITS_HI   = 4'd15;

  // accepted format values
  localparam logic [15:0] FORMAT_PCM  = 16'd1;
  localparam logic [15:0] CHANNELS_OK = 16'd1;
  localparam logic [15:0] BITS_OK     = 16'd16;

  // result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // parse phases
  typedef enum logic [2:0] {
    PH_RIFF,
    PH_RSIZE,
    PH_WAVE,
    PH_HEADER,
    PH_FMT,
    PH_SKIP,
    PH_DONE
  } phase_t;

  // one input byte
  typedef struct packed {
    logic [7:0] byte_value;
    logic       last;
  } in_t;

  // one result
  typedef struct packed {
    logic        status;
    logic [31:0] payload_offset;
    logic [31:0] payload_length;
    logic [31:0] rate_hz;
  } out_t;

endpackage

>>> rtl/core/wavhp_core.sv
// wavhp_core: per-stream parse state and the single-byte update logic
// depends on wavhp_pkg
module wavhp_core #(
  parameter int POSITION_BITS = wavhp_pkg::POSITION_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  wavhp_pkg::in_t item,
  output wavhp_pkg::out_t res
);
  import wavhp_pkg::*;

  localparam int PB = POSITION_BITS;

  // state registers
  phase_t         phase_r, phase_nxt;
  logic [PB-1:0]  pos_r, pos_nxt;
  logic [63:0]    hs_r, hs_nxt;
  logic [32:0]    skip_r, skip_nxt;
  logic [3:0]     fidx_r, fidx_nxt;
  logic [15:0]    format_r, format_nxt;
  logic [15:0]    chan_r, chan_nxt;
  logic [15:0]    bits_r, bits_nxt;
  logic [31:0]    rate_r, rate_nxt;
  logic [PB-1:0]  start_r, start_nxt;
  logic [31:0]    size_r, size_nxt;
  logic           found_r, found_nxt;
  logic           failed_r, failed_nxt;

  // helpers
  logic           at_max;
  logic [PB-1:0]  pos_inc;
  logic [63:0]    hs_shift;
  logic [31:0]    hdr_id;
  logic [31:0]    hdr_size;
  logic [32:0]    hdr_total;
  logic [32:0]    skip_dec;
  logic [31:0]    p32;
  logic [31:0]    count32;
  logic [31:0]    start32;
  logic [31:0]    avail;
  logic           bad;

  assign at_max    = &pos_r;
  assign pos_inc   = pos_r + 1'b1;
  assign hs_shift  = {item.byte_value, hs_r[63:8]};
  assign hdr_id    = hs_shift[31:0];
  assign hdr_size  = hs_shift[63:32];
  assign hdr_total = {1'b0, hdr_size} + 33'(hdr_size[0]);
  assign skip_dec  = skip_r - 1'b1;
  assign p32       = 32'(pos_r);

  // next state and result
  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    hs_nxt     = hs_r;
    skip_nxt   = skip_r;
    fidx_nxt   = fidx_r;
    format_nxt = format_r;
    chan_nxt   = chan_r;
    bits_nxt   = bits_r;
    rate_nxt   = rate_r;
    start_nxt  = start_r;
    size_nxt   = size_r;
    found_nxt  = found_r;
    failed_nxt = failed_r;

    // position counter saturates and flags an overlong stream
    if (at_max) begin
      failed_nxt = 1'b1;
    end else begin
      pos_nxt = pos_inc;
    end

    if (!failed_nxt) begin
      case (phase_r)
        PH_RIFF: begin
          hs_nxt = hs_shift;
          if (p32 == POS_RIFF_END) begin
            if (hs_shift[63:32] != TAG_RIFF) failed_nxt = 1'b1;
            phase_nxt = PH_RSIZE;
          end
        end
        PH_RSIZE: begin
          if (p32 == POS_RSIZE_END) phase_nxt = PH_WAVE;
        end
        PH_WAVE: begin
          hs_nxt = hs_shift;
          if (p32 == POS_WAVE_END) begin
            if (hs_shift[63:32] != TAG_WAVE) begin
              failed_nxt = 1'b1;
            end else begin
              phase_nxt = PH_HEADER;
              skip_nxt  = CHUNK_HDR;
              hs_nxt    = '0;
            end
          end
        end
        PH_HEADER: begin
          hs_nxt   = hs_shift;
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            if (hdr_id == TAG_FMT && hdr_size >= FMT_MIN) begin
              phase_nxt = PH_FMT;
              skip_nxt  = hdr_total;
              fidx_nxt  = '0;
            end else if (hdr_id == TAG_DATA) begin
              if (rate_r == '0) begin
                failed_nxt = 1'b1;
              end else begin
                start_nxt = pos_inc;
                size_nxt  = hdr_size;
                found_nxt = 1'b1;
                phase_nxt = PH_DONE;
              end
            end else if (hdr_total == '0) begin
              phase_nxt = PH_HEADER;
              skip_nxt  = CHUNK_HDR;
              hs_nxt    = '0;
            end else begin
              phase_nxt = PH_SKIP;
              skip_nxt  = hdr_total;
            end
          end
        end
        PH_FMT: begin
          // pick up the fields of the fmt body
          case (fidx_r)
            FMT_FORMAT_LO: format_nxt[7:0]  = item.byte_value;
            FMT_FORMAT_HI: format_nxt[15:8] = item.byte_value;
            FMT_CHAN_LO:   chan_nxt[7:0]    = item.byte_value;
            FMT_CHAN_HI:   chan_nxt[15:8]   = item.byte_value;
            FMT_RATE_B0:   rate_nxt[7:0]    = item.byte_value;
            FMT_RATE_B1:   rate_nxt[15:8]   = item.byte_value;
            FMT_RATE_B2:   rate_nxt[23:16]  = item.byte_value;
            FMT_RATE_B3:   rate_nxt[31:24]  = item.byte_value;
            FMT_BITS_LO:   bits_nxt[7:0]    = item.byte_value;
            FMT_BITS_HI:   bits_nxt[15:8]   = item.byte_value;
            default: ;
          endcase
          skip_nxt = skip_dec;
          fidx_nxt = fidx_r + 1'b1;
          if (fidx_r == FMT_BITS_HI) begin
            if (format_nxt != FORMAT_PCM || chan_nxt != CHANNELS_OK ||
                bits_nxt != BITS_OK || rate_nxt == '0) begin
              failed_nxt = 1'b1;
            end else if (skip_dec == '0) begin
              phase_nxt = PH_HEADER;
              skip_nxt  = CHUNK_HDR;
              hs_nxt    = '0;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) begin
            phase_nxt = PH_HEADER;
            skip_nxt  = CHUNK_HDR;
            hs_nxt    = '0;
          end
        end
        default: ;
      endcase
    end

    // result from the updated state
    count32 = 32'(pos_nxt);
    start32 = 32'(start_nxt);
    avail   = count32 - start32;
    bad     = failed_nxt || !found_nxt || count32 < MIN_STREAM || start32 > count32;
    if (bad) begin
      res = '{status: STATUS_BAD, payload_offset: '0, payload_length: '0,
              rate_hz: '0};
    end else begin
      res.status         = STATUS_OK;
      res.payload_offset = start32;
      res.payload_length = (size_nxt > avail) ? avail : size_nxt;
      res.rate_hz        = rate_nxt;
    end

    // last byte closes the stream
    if (item.last) begin
      phase_nxt  = PH_RIFF;
      pos_nxt    = '0;
      hs_nxt     = '0;
      skip_nxt   = '0;
      fidx_nxt   = '0;
      format_nxt = '0;
      chan_nxt   = '0;
      bits_nxt   = '0;
      rate_nxt   = '0;
      start_nxt  = '0;
      size_nxt   = '0;
      found_nxt  = 1'b0;
      failed_nxt = 1'b0;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_RIFF;
      pos_r    <= '0;
      hs_r     <= '0;
      skip_r   <= '0;
      fidx_r   <= '0;
      format_r <= '0;
      chan_r   <= '0;
      bits_r   <= '0;
      rate_r   <= '0;
      start_r  <= '0;
      size_r   <= '0;
      found_r  <= 1'b0;
      failed_r <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      hs_r     <= hs_nxt;
      skip_r   <= skip_nxt;
      fidx_r   <= fidx_nxt;
      format_r <= format_nxt;
      chan_r   <= chan_nxt;
      bits_r   <= bits_nxt;
      rate_r   <= rate_nxt;
      start_r  <= start_nxt;
      size_r   <= size_nxt;
      found_r  <= found_nxt;
      failed_r <= failed_nxt;
    end
  end

  // a closing byte leaves the parser at the start of a new stream
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.last |=> pos_r == '0 && phase_r == PH_RIFF && !found_r)
    else $error("stream state not cleared after last byte");

  // the done phase is only reached with a recorded data chunk
  a_done_found: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |-> found_r && rate_r != '0)
    else $error("done phase without data chunk");

  // a data chunk can never start before the first chunk body
  a_start_min: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> 32'(start_r) >= MIN_DATA_OFF)
    else $error("payload offset below minimum");

endmodule

>>> rtl/core/wav_pcm16_header_parser.sv
// wav_pcm16_header_parser: top level with input and result registers
// depends on wavhp_pkg and wavhp_core
//
//  channel  | ports                          | payload
//  ---------+--------------------------------+---------------------------
//  input    | in_valid, in_stall, in_item    | byte_value, last
//  result   | out_valid, out_stall, out_item | status, offset, length, rate
//
// one byte per cycle is taken while in_stall is low; the last byte of a stream
// passes the input register, then its result is loaded into the result register.
// the parse state updates in a single pass from the input register.
// reset (rst_n low, synchronous) clears the parse state and both valid flags.
// input stalls only while a last byte waits behind a held, stalled result.
module wav_pcm16_header_parser #(
  parameter int POSITION_BITS = wavhp_pkg::POSITION_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  wavhp_pkg::in_t  in_item,
  output logic            out_valid,
  input  logic            out_stall,
  output wavhp_pkg::out_t out_item
);
  import wavhp_pkg::*;

  logic  s1_valid_r;
  in_t   s1_item_r;
  logic  out_valid_r;
  out_t  out_item_r;
  out_t  core_res;
  logic  out_free;
  logic  s1_go;
  logic  in_take;
  logic  out_load;

  // stage control
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!s1_item_r.last || out_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;
  assign out_load = s1_go && s1_item_r.last;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
  end

  // parse state and update logic
  wavhp_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .step (s1_go),
    .item (s1_item_r),
    .res  (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // back-pressure only comes from a held result with a last byte waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_item_r.last && out_valid_r && out_stall)
    else $error("input stalled without a blocked result");

  // a processed last byte always produces a result transfer candidate
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_item_r.last |=> out_valid_r)
    else $error("last byte gave no result");

  // rejected results carry zero fields
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.status == STATUS_BAD |->
      out_item_r.payload_offset == '0 && out_item_r.payload_length == '0 &&
      out_item_r.rate_hz == '0)
    else $error("rejected result with nonzero fields");

endmodule

>>> verif/wav_header_tracker_pkg.sv
// wav_header_tracker_pkg: result predictor and checker for the wav header parser bench
// depends on wavhp_pkg for the item types, tags and phase names
package wav_header_tracker_pkg;
  import wavhp_pkg::*;

  // highest byte position the counter can hold
  localparam bit [31:0] POS_LIMIT = 32'hFFFF_FFFF;
  // mismatches printed in full, later ones only counted
  localparam int REPORT_LIMIT = 10;

  class wav_header_tracker;
    // parser state mirrored from the block
    phase_t    phase;
    bit [31:0] pos;
    bit [63:0] hdr;
    bit [32:0] left;
    bit [15:0] f_format;
    bit [15:0] f_chans;
    bit [15:0] f_bits;
    bit [31:0] rate;
    bit [31:0] pay_start;
    bit [31:0] pay_size;
    bit        pay_found;
    bit        bad;

    // verdicts waiting for their result transfer
    out_t pending_verdicts[$];
    int   results_seen;
    int   ok_count;
    int   bad_count;
    int   errors;

    function new();
      clear();
    endfunction

    function void clear();
      phase     = PH_RIFF;
      pos       = '0;
      hdr       = '0;
      left      = '0;
      f_format  = '0;
      f_chans   = '0;
      f_bits    = '0;
      rate      = '0;
      pay_start = '0;
      pay_size  = '0;
      pay_found = 1'b0;
      bad       = 1'b0;
    endfunction

    function bit [32:0] padded(bit [31:0] n);
      return {1'b0, n} + n[0];
    endfunction

    function void start_chunk_header();
      phase = PH_HEADER;
      left  = CHUNK_HDR;
      hdr   = '0;
    endfunction

    // one byte through the chunk walk
    function void advance_parse(bit [31:0] p, bit [7:0] b);
      bit [32:0] i;
      bit [31:0] id;
      bit [31:0] csize;
      case (phase)
        PH_RIFF: begin
          hdr = {b, hdr[63:8]};
          if (p == POS_RIFF_END) begin
            if (hdr[63:32] != TAG_RIFF) bad = 1'b1;
            phase = PH_RSIZE;
          end
        end
        PH_RSIZE: begin
          if (p == POS_RSIZE_END) phase = PH_WAVE;
        end
        PH_WAVE: begin
          hdr = {b, hdr[63:8]};
          if (p == POS_WAVE_END) begin
            if (hdr[63:32] != TAG_WAVE) bad = 1'b1;
            else start_chunk_header();
          end
        end
        PH_HEADER: begin
          hdr  = {b, hdr[63:8]};
          left = left - 1;
          if (left == 0) begin
            id    = hdr[31:0];
            csize = hdr[63:32];
            if (id == TAG_FMT && csize >= FMT_MIN) begin
              phase = PH_FMT;
              left  = padded(csize);
            end else if (id == TAG_DATA) begin
              // a data header needs a good fmt chunk ahead of it
              if (rate == 0) begin
                bad = 1'b1;
              end else begin
                pay_start = p + 1;
                pay_size  = csize;
                pay_found = 1'b1;
                phase     = PH_DONE;
              end
            end else if (padded(csize) == 0) begin
              start_chunk_header();
            end else begin
              phase = PH_SKIP;
              left  = padded(csize);
            end
          end
        end
        PH_FMT: begin
          // offset inside the fmt body
          i = padded(hdr[63:32]) - left;
          if (i < 2) f_format[8*i[0] +: 8] = b;
          else if (i < 4) f_chans[8*i[0] +: 8] = b;
          else if (i < 8) rate[8*i[1:0] +: 8] = b;
          else if (i == 14 || i == 15) f_bits[8*i[0] +: 8] = b;
          left = left - 1;
          if (i == 15) begin
            if (f_format != FORMAT_PCM || f_chans != CHANNELS_OK || f_bits != BITS_OK ||
                rate == 0)
              bad = 1'b1;
            else if (left == 0)
              start_chunk_header();
            else
              phase = PH_SKIP;
          end
        end
        PH_SKIP: begin
          left = left - 1;
          if (left == 0) start_chunk_header();
        end
        default: ;
      endcase
    endfunction

    // note an accepted input transfer, queue a verdict on the last byte
    function void take_byte(in_t item);
      bit [31:0] p;
      bit [31:0] count;
      bit [31:0] len;
      out_t      want;
      p = pos;
      if (p >= POS_LIMIT) bad = 1'b1;
      else pos = p + 1;
      if (!bad) advance_parse(p, item.byte_value);
      if (!item.last) return;
      count = pos;
      want  = '0;
      if (bad || !pay_found || count < MIN_STREAM || pay_start > count) begin
        want.status = STATUS_BAD;
      end else begin
        len = pay_size;
        if (len > count - pay_start) len = count - pay_start;
        want.status         = STATUS_OK;
        want.payload_offset = pay_start;
        want.payload_length = len;
        want.rate_hz        = rate;
      end
      pending_verdicts.push_back(want);
      clear();
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    // compare one result transfer with the oldest verdict
    function void check_result(out_t got);
      out_t want;
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        note_error($sformatf("unexpected result: status %0d offset %0d length %0d rate %0d",
                             got.status, got.payload_offset, got.payload_length,
                             got.rate_hz));
        return;
      end
      want = pending_verdicts.pop_front();
      if (want.status == STATUS_OK) ok_count++;
      else bad_count++;
      if (got.status !== want.status || got.payload_offset !== want.payload_offset ||
          got.payload_length !== want.payload_length ||
          got.rate_hz !== want.rate_hz)
        note_error($sformatf({"result %0d: expected status %0d offset %0d length %0d",
                              " rate %0d, got status %0d offset %0d length %0d rate %0d"},
                             results_seen, want.status, want.payload_offset,
                             want.payload_length, want.rate_hz, got.status,
                             got.payload_offset, got.payload_length, got.rate_hz));
    endfunction
  endclass

endpackage

>>> verif/tb_wav_pcm16_header_parser.sv
// tb_wav_pcm16_header_parser: byte stream bench for the wav pcm16 header parser
// depends on wavhp_pkg, wav_header_tracker_pkg and the wav_pcm16_header_parser rtl
module tb_wav_pcm16_header_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import wavhp_pkg::*;
  import wav_header_tracker_pkg::*;

  localparam bit [31:0] TAG_LIST       = 32'h5453_494C;
  localparam int        RANDOM_BYTES   = 400;
  localparam int        RANDOM_STREAMS = 6;
  localparam int        HOLD_CYCLES    = 300;
  localparam int        DRAIN_CYCLES   = 16;
  localparam int        CYCLE_LIMIT    = 600000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_item;
  logic out_valid;
  logic out_stall;
  out_t out_item;

  wav_header_tracker book;
  bit [7:0]          wav_bytes[$];
  bit                tx_calm;
  bit                hold_req;
  int                bytes_sent;
  int                streams_sent;
  int                input_stall_cycles;
  int unsigned       cycle_count = 0;

  wav_pcm16_header_parser uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_wav_pcm16_header_parser: errors");
      $finish;
    end
  end

  // stream building helpers; all but padded_len append to wav_bytes
  function automatic int padded_len(bit [31:0] n);
    return n + n[0];
  endfunction

  function automatic void add_word(bit [31:0] v);
    for (int k = 0; k < 4; k++) wav_bytes.push_back(v[8*k +: 8]);
  endfunction

  function automatic void add_noise(int n);
    repeat (n) wav_bytes.push_back(8'($urandom));
  endfunction

  function automatic void add_riff();
    add_word(TAG_RIFF);
    add_word($urandom);
    add_word(TAG_WAVE);
  endfunction

  function automatic void add_chunk(bit [31:0] tag, bit [31:0] csize, int emit);
    add_word(tag);
    add_word(csize);
    add_noise(emit);
  endfunction

  function automatic void add_data(bit [31:0] csize, int present);
    add_chunk(TAG_DATA, csize, present);
  endfunction

  // fmt chunk with only the first emit body bytes written
  function automatic void add_fmt(bit [31:0] csize, bit [15:0] fcode, bit [15:0] chans,
                                  bit [15:0] width, bit [31:0] rate, int emit);
    add_word(TAG_FMT);
    add_word(csize);
    for (int k = 0; k < emit; k++) begin
      if (k < 2) wav_bytes.push_back(fcode[8*k +: 8]);
      else if (k < 4) wav_bytes.push_back(chans[8*(k-2) +: 8]);
      else if (k < 8) wav_bytes.push_back(rate[8*(k-4) +: 8]);
      else if (k == 14 || k == 15) wav_bytes.push_back(width[8*(k-14) +: 8]);
      else wav_bytes.push_back(8'($urandom));
    end
  endfunction

  function automatic void add_good_fmt(bit [31:0] rate);
    add_fmt(FMT_MIN, FORMAT_PCM, CHANNELS_OK, BITS_OK, rate, 16);
  endfunction

  // unknown, list or short fmt chunk with its pad byte
  function automatic void add_filler_chunk();
    bit [31:0] csize;
    csize = $urandom_range(0, 9);
    case ($urandom_range(0, 2))
      0:       add_chunk(TAG_LIST, csize, padded_len(csize));
      1:       add_chunk(TAG_FMT, csize, padded_len(csize));
      default: add_chunk($urandom, csize, padded_len(csize));
    endcase
  endfunction

  // mostly well formed files with random content, some broken on purpose
  function automatic void compose_random_wav();
    int        shape;
    int        keep;
    bit [31:0] fsize;
    bit [31:0] rate;
    bit [15:0] fcode;
    bit [15:0] chans;
    bit [15:0] width;
    shape = $urandom_range(0, 99);
    rate  = $urandom;
    fcode = FORMAT_PCM;
    chans = CHANNELS_OK;
    width = BITS_OK;
    fsize = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 26) : FMT_MIN;
    // one fmt field spoilt
    if (shape < 8) begin
      case ($urandom_range(0, 3))
        0:       fcode = 16'($urandom);
        1:       chans = 16'($urandom);
        2:       width = 16'($urandom);
        default: rate = '0;
      endcase
    end
    add_riff();
    repeat ($urandom_range(0, 2)) add_filler_chunk();
    // data header ahead of the fmt chunk
    if (shape >= 8 && shape < 13) add_data($urandom_range(0, 8), $urandom_range(0, 8));
    add_fmt(fsize, fcode, chans, width, rate, padded_len(fsize));
    if ($urandom_range(0, 3) == 0) add_filler_chunk();
    if ($urandom_range(0, 7) == 0) add_good_fmt($urandom);
    add_data(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 10),
             $urandom_range(0, 12));
    // truncated, corrupted or pure noise
    if (shape >= 13 && shape < 25) begin
      keep = $urandom_range(1, wav_bytes.size() - 1);
      while (wav_bytes.size() > keep) void'(wav_bytes.pop_back());
    end else if (shape >= 25 && shape < 33) begin
      wav_bytes[$urandom_range(0, wav_bytes.size() - 1)] = 8'($urandom);
    end else if (shape >= 33 && shape < 41) begin
      wav_bytes.delete();
      add_noise($urandom_range(1, 60));
    end
  endfunction

  // one input transfer, entered and left at a falling edge
  task automatic send_byte(bit [7:0] value, bit is_last);
    int  gap;
    in_t item;
    gap             = tx_calm ? 0 : $urandom_range(0, 15);
    item.byte_value = value;
    item.last       = is_last;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) begin
      input_stall_cycles++;
      @(posedge clk);
    end
    book.take_byte(item);
    @(negedge clk);
  endtask

  // send wav_bytes as one stream, last flag on the final byte
  task automatic send_wav(bit back_to_back = 1'b0);
    if (back_to_back) tx_calm = 1'b1;
    else if ($urandom_range(0, 4) == 0) tx_calm = !tx_calm;
    foreach (wav_bytes[k]) send_byte(wav_bytes[k], k == wav_bytes.size() - 1);
    bytes_sent += wav_bytes.size();
    streams_sent++;
    wav_bytes.delete();
  endtask

  // result side: random stalls, one long hold on request
  initial begin : result_sink
    int n;
    bit rx_calm;
    bit hold_taken;
    rx_calm    = 1'b0;
    hold_taken = 1'b0;
    out_stall  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 5) == 0) rx_calm = !rx_calm;
      n = rx_calm ? 0 : $urandom_range(0, 15);
      if (hold_req && !hold_taken) begin
        n          = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      book.check_result(out_item);
    end
  end

  // stimulus and end of run
  initial begin : stimulus
    int rand_bytes;
    int rand_streams;
    book        = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    tx_calm     = 1'b0;
    hold_req    = 1'b0;
    rand_bytes  = 0;
    rand_streams = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single byte marked last
    wav_bytes.push_back(8'hFF);
    send_wav();
    // smallest valid file, empty payload
    add_riff();
    add_good_fmt(32'd16000);
    add_data(32'd0, 0);
    send_wav();
    // one byte short of the minimum length
    add_riff();
    add_good_fmt(32'd8000);
    add_data(32'd0, 0);
    void'(wav_bytes.pop_back());
    send_wav();
    // data length far beyond the buffer, all-ones rate
    add_riff();
    add_good_fmt('1);
    add_data('1, 5);
    send_wav();
    // bad riff magic
    add_riff();
    wav_bytes[0] = 8'h72;
    add_good_fmt(32'd44100);
    add_data(32'd4, 4);
    send_wav();
    // bad wave magic
    add_riff();
    wav_bytes[11] = wav_bytes[11] ^ 8'h20;
    add_good_fmt(32'd44100);
    add_data(32'd4, 4);
    send_wav();
    // data header before any fmt chunk
    add_riff();
    add_data(32'd8, 8);
    add_good_fmt(32'd22050);
    add_data(32'd2, 2);
    send_wav();
    // short fmt chunk skipped with its pad, then a good one
    add_riff();
    add_fmt(32'd15, 16'hFFFF, 16'h0000, 16'h0000, 32'd0, 16);
    add_good_fmt(32'd11025);
    add_data(32'd6, 6);
    send_wav();
    // odd fmt with pad, empty and odd chunks, payload shorter than the tail
    add_riff();
    add_fmt(32'd17, FORMAT_PCM, CHANNELS_OK, BITS_OK, 32'd48000, 18);
    add_chunk(TAG_LIST, 32'd0, 0);
    add_chunk($urandom, 32'd3, 4);
    add_data(32'd2, 7);
    send_wav();
    // wrong format, channels, bits, then a zero rate
    for (int k = 0; k < 4; k++) begin
      add_riff();
      add_fmt(FMT_MIN, (k == 0) ? 16'd3 : FORMAT_PCM, (k == 1) ? 16'd2 : CHANNELS_OK,
              (k == 2) ? 16'd8 : BITS_OK, (k == 3) ? 32'd0 : 32'd16000, 16);
      add_data(32'd4, 4);
      send_wav();
    end
    // fmt chunk cut off by the end of the stream
    add_riff();
    add_chunk(TAG_LIST, 32'd16, 16);
    add_fmt(FMT_MIN, FORMAT_PCM, CHANNELS_OK, BITS_OK, 32'd8000, 10);
    send_wav();
    // fmt of maximal size never finishes its skip
    add_riff();
    add_fmt('1, FORMAT_PCM, CHANNELS_OK, BITS_OK, 32'd8000, 20);
    add_noise(20);
    send_wav();
    // a later fmt chunk replaces the rate
    add_riff();
    add_good_fmt(32'd8000);
    add_good_fmt(32'd96000);
    add_data(32'd3, 3);
    send_wav();
    // a bad second fmt rejects the file
    add_riff();
    add_good_fmt(32'd8000);
    add_fmt(FMT_MIN, FORMAT_PCM, CHANNELS_OK, 16'd8, 32'd96000, 16);
    add_data(32'd3, 3);
    send_wav();
    // trailing bytes after a rejection
    add_riff();
    wav_bytes[2] = 8'h00;
    add_noise(80);
    send_wav();
    // stream ends inside the data header
    add_riff();
    add_chunk($urandom, 32'd8, 8);
    add_good_fmt(32'd16000);
    add_word(TAG_DATA);
    add_noise(2);
    send_wav();

    // tiny streams back to back while the result side holds off
    hold_req = 1'b1;
    repeat (8) begin
      add_noise($urandom_range(1, 2));
      send_wav(1'b1);
    end

    // random files
    while (rand_bytes < RANDOM_BYTES || rand_streams < RANDOM_STREAMS) begin
      compose_random_wav();
      rand_bytes += wav_bytes.size();
      rand_streams++;
      send_wav();
    end
    in_valid <= 1'b0;

    // drain
    while (book.pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d streams (%0d bytes); %0d results checked: %0d good files, %0d rejected",
             streams_sent, bytes_sent, book.results_seen, book.ok_count, book.bad_count);
    $display("input stalled for %0d cycles behind held results", input_stall_cycles);
    if (book.errors == 0 && book.pending_verdicts.size() == 0)
      $display("tb_wav_pcm16_header_parser: clean");
    else
      $display("tb_wav_pcm16_header_parser: errors");
    $finish;
  end

endmodule

>>> wav_pcm16_header_parser.f
rtl/core/wavhp_pkg.sv
rtl/core/wavhp_core.sv
rtl/core/wav_pcm16_header_parser.sv
verif/wav_header_tracker_pkg.sv
verif/tb_wav_pcm16_header_parser.sv
